>>> sv/ppv_pkg.sv
`timescale 1ns / 1ps

package ppv_pkg;

  // Number of character fields that one word carries.
  localparam int NUM_FIELDS = 7;

  // Code reported for a position that received no vote.
  localparam logic [7:0] EMPTY_MARK = 8'd42;

  typedef struct packed {
    logic [7:0] char_0;
    logic [7:0] char_1;
    logic [7:0] char_2;
    logic [7:0] char_3;
    logic [7:0] char_4;
    logic [7:0] char_5;
    logic [7:0] char_6;
    logic       has_vote;
    logic       last_vote;
  } vote_t;

  typedef struct packed {
    logic [7:0] winner_0;
    logic [7:0] winner_1;
    logic [7:0] winner_2;
    logic [7:0] winner_3;
    logic [7:0] winner_4;
    logic [7:0] winner_5;
    logic [7:0] winner_6;
    logic       count_saturated;
  } result_t;

  // Commands from the sequencer to every lane.
  typedef struct packed {
    logic vote_read;   // read the counter addressed by the incoming code
    logic vote_write;  // write back the incremented counter
    logic sweep;       // read the sweep address and write zero there
    logic restart;     // forget the best code found so far
    logic track;       // read data belongs to the previous sweep address
  } lane_ctrl_t;

  // What a lane reports back.
  typedef struct packed {
    logic [7:0] winner;
    logic       sat_hit;
  } lane_stat_t;

endpackage

>>> sv/ppv_ram.sv
`timescale 1ns / 1ps

module ppv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Read-first: a read and a write to the same address return the old data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/ppv_lane.sv
`timescale 1ns / 1ps

module ppv_lane import ppv_pkg::*; #(
  parameter int COUNT_BITS  = 8,
  parameter int CODE_VALUES = 256,
  localparam int AW = $clog2(CODE_VALUES)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lane_ctrl_t  ctrl_i,
  input  logic [7:0]  code_i,
  input  logic [AW-1:0] sweep_addr_i,
  input  logic [AW-1:0] track_code_i,
  output lane_stat_t  stat_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_NEAR = {{(COUNT_BITS-1){1'b1}}, 1'b0};

  logic [AW-1:0]         code_q;
  logic                  hit_q;
  logic                  best_found_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic [AW-1:0]         best_code_q;

  logic                  hit;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] bumped;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [AW-1:0]         rd_addr;

  // Codes beyond the counter table are not counted.
  assign hit = 9'(code_i) < 9'(CODE_VALUES);

  assign bumped  = (rd_data == CNT_MAX) ? rd_data : rd_data + COUNT_BITS'(1);
  assign rd_addr = ctrl_i.sweep ? sweep_addr_i : code_i[AW-1:0];
  assign wr_en   = ctrl_i.sweep | (ctrl_i.vote_write & hit_q);
  assign wr_addr = ctrl_i.sweep ? sweep_addr_i : code_q;
  assign wr_data = ctrl_i.sweep ? '0 : bumped;

  ppv_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CODE_VALUES)
  ) u_counts (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (ctrl_i.vote_read) begin
        hit_q <= hit;
      end
      if (ctrl_i.restart) begin
        best_found_q <= 1'b0;
      end else if (ctrl_i.track && (!best_found_q || rd_data > best_cnt_q) &&
                   rd_data != '0) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vote_read) begin
      code_q <= code_i[AW-1:0];
    end
    // Strictly greater keeps the smallest code on a tie.
    if (ctrl_i.track && (!best_found_q || rd_data > best_cnt_q) && rd_data != '0) begin
      best_cnt_q  <= rd_data;
      best_code_q <= track_code_i;
    end
  end

  assign stat_o.winner  = best_found_q ? 8'(best_code_q) : EMPTY_MARK;
  assign stat_o.sat_hit = ctrl_i.vote_write & hit_q & (rd_data >= CNT_NEAR);

endmodule

>>> sv/ppv_merge.sv
`timescale 1ns / 1ps

module ppv_merge import ppv_pkg::*; #(
  parameter int LANES = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       emit_i,
  input  logic       votes_seen_i,
  input  logic       sat_seen_i,
  input  lane_stat_t lane_stat_i [LANES],
  output logic       done_o,
  output result_t    result_o
);

  logic [7:0] win [NUM_FIELDS];
  logic       done_q;
  result_t    result_q;

  for (genvar p = 0; p < NUM_FIELDS; p++) begin : g_pos
    if (p < LANES) begin : g_lane
      assign win[p] = votes_seen_i ? lane_stat_i[p].winner : EMPTY_MARK;
    end else begin : g_none
      assign win[p] = EMPTY_MARK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      result_q.winner_0        <= win[0];
      result_q.winner_1        <= win[1];
      result_q.winner_2        <= win[2];
      result_q.winner_3        <= win[3];
      result_q.winner_4        <= win[4];
      result_q.winner_5        <= win[5];
      result_q.winner_6        <= win[6];
      result_q.count_saturated <= sat_seen_i;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> sv/per_position_plurality_vote_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// vote      in         start high, busy low       vote_i   (vote_t)
// result    out        done_o strobe, one cycle   result_o (result_t)
//
// For a word with a vote, the counters are read in the cycle the word is
// taken and written back in the next, as each lane's counter memory has a
// single write port. A closing word then sweeps the counters, one code per
// cycle, through all CODE_VALUES codes, then passes the drain and finish
// states to settle and merge; the result strobes in the cycle busy falls.
// After reset the block clears its counters, with busy high. The receiver
// cannot stall, so the result strobe is never held back.

module per_position_plurality_vote_core import ppv_pkg::*; #(
  parameter int NUM_POSITIONS = 7,
  parameter int COUNT_BITS    = 8,
  parameter int CODE_VALUES   = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  vote_t   vote_i,
  output logic    done_o,
  output result_t result_o
);

  // Only positions that have both a field and a configured position vote.
  localparam int LANES = (NUM_POSITIONS < NUM_FIELDS) ? NUM_POSITIONS : NUM_FIELDS;
  localparam int AW    = $clog2(CODE_VALUES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CODE_VALUES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e     state_q;
  logic       last_q;
  logic [AW-1:0] addr_q;
  logic       track_q;
  logic [AW-1:0] track_addr_q;
  logic       votes_seen_q;
  logic       sat_seen_q;

  logic       accept;
  logic       any_sat;
  lane_ctrl_t ctrl;
  logic [7:0] codes [NUM_FIELDS];
  lane_stat_t lane_stat [LANES];

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  assign codes[0] = vote_i.char_0;
  assign codes[1] = vote_i.char_1;
  assign codes[2] = vote_i.char_2;
  assign codes[3] = vote_i.char_3;
  assign codes[4] = vote_i.char_4;
  assign codes[5] = vote_i.char_5;
  assign codes[6] = vote_i.char_6;

  // Lane commands. The sweep both reads each counter for the winner search
  // and clears it behind itself, so the store is empty when the result leaves.
  always_comb begin
    ctrl.vote_read  = accept && vote_i.has_vote;
    ctrl.vote_write = (state_q == ST_UPDATE);
    ctrl.sweep      = (state_q == ST_CLEAR) || (state_q == ST_SCAN);
    ctrl.restart    = (state_q == ST_SCAN) && (addr_q == '0);
    ctrl.track      = track_q;
  end

  always_comb begin
    any_sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      any_sat = any_sat | lane_stat[l].sat_hit;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ppv_lane #(
      .COUNT_BITS  (COUNT_BITS),
      .CODE_VALUES (CODE_VALUES)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .code_i       (codes[l]),
      .sweep_addr_i (addr_q),
      .track_code_i (track_addr_q),
      .stat_o       (lane_stat[l])
    );
  end

  // Sequencer: the clearing pass after reset, the write-back of a vote, and
  // the sweep that finds the winners once a set is closed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      last_q       <= 1'b0;
      addr_q       <= '0;
      track_q      <= 1'b0;
      track_addr_q <= '0;
      votes_seen_q <= 1'b0;
      sat_seen_q   <= 1'b0;
    end else begin
      track_q      <= (state_q == ST_SCAN);
      track_addr_q <= addr_q;
      unique case (state_q)
        ST_CLEAR: begin
          if (addr_q == LAST_ADDR) begin
            addr_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            last_q <= vote_i.last_vote;
            if (vote_i.has_vote) begin
              state_q <= ST_UPDATE;
            end else if (vote_i.last_vote) begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_UPDATE: begin
          votes_seen_q <= 1'b1;
          sat_seen_q   <= sat_seen_q | any_sat;
          state_q      <= last_q ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (addr_q == LAST_ADDR) begin
            addr_q  <= '0;
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          // The last counter read is being compared in this cycle.
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          // The merge stage takes the winners at this edge.
          votes_seen_q <= 1'b0;
          sat_seen_q   <= 1'b0;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

  ppv_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (state_q == ST_FINISH),
    .votes_seen_i (votes_seen_q),
    .sat_seen_i   (sat_seen_q),
    .lane_stat_i  (lane_stat),
    .done_o       (done_o),
    .result_o     (result_o)
  );

  // A result always follows a drained sweep and the merge cycle.
  a_done_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q, 2) == ST_DRAIN))
    else $error("result strobe without a completed sweep");

  // The result strobes while the block is ready for the next word.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A write-back always follows a taken word that carried a vote.
  a_update_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> ($past(accept) && $past(vote_i.has_vote)))
    else $error("counter write-back without a taken vote");

  // A taken vote keeps the block busy for its write-back.
  a_vote_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && vote_i.has_vote) |=> busy)
    else $error("vote taken without write-back cycle");

endmodule
